// ===== rtl/tofd_pkg.sv =====
// Shared types, constants and the arctangent table for the ToF depth pipeline.
package tofd_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int PHASE_BITS   = 16;
  localparam int IW           = SAMPLE_BITS + 1;
  localparam int CORDIC_STEPS = 30;
  localparam int XW           = IW + 32;
  localparam int ZW           = 37;
  localparam int TW           = 35;
  localparam int TLW          = 17;
  localparam int INVW         = 27;
  localparam int SUMW         = 63;
  localparam int PW           = PHASE_BITS + 1;
  localparam int DW           = PHASE_BITS + 19;
  localparam int MAGW         = 2 * IW;
  localparam int ROOTW        = MAGW / 2;
  localparam int REMW         = ROOTW + 3;
  localparam int SQRT_STEPS   = ROOTW;
  localparam int DIV_STEPS    = 17;
  localparam int LATENCY      = CORDIC_STEPS + 7 + DIV_STEPS;
  localparam int AMP_DLY      = LATENCY - 1 - (2 + SQRT_STEPS);

  localparam logic signed [ZW-1:0] PI_Q32     = ZW'(64'sd13493037705);
  localparam logic [TW-1:0]        TWO_PI_Q32 = TW'(64'd26986075410);
  localparam logic [INVW-1:0]      INV_TWO_PI = INVW'(85445659);

  localparam logic CFG_RANGE  = 1'b0;
  localparam logic CFG_OFFSET = 1'b1;

  typedef struct packed {
    logic signed [15:0] first_plane_sample;
    logic signed [15:0] second_plane_sample;
    logic signed [15:0] third_plane_sample;
    logic signed [15:0] fourth_plane_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [16:0] depth_mm;
    logic [15:0]        amplitude;
  } out_word_t;

  // unsigned quotient of a non-negative numerator, shift and subtract
  function automatic longint udiv(longint num, longint den);
    longint qt;
    longint rm;
    qt = 0;
    rm = 0;
    for (int b = 62; b >= 0; b--) begin
      rm = (rm << 1) | ((num >> b) & longint'(1));
      qt = qt << 1;
      if (rm >= den) begin
        rm = rm - den;
        qt = qt | longint'(1);
      end
    end
    return qt;
  endfunction

  // atan(2^-k) in Q32 from the alternating series, rounded
  function automatic longint atan_entry(int k);
    longint s;
    longint term;
    int     n;
    int     sgn;
    s   = 0;
    sgn = 1;
    if (k == 0) begin
      s = 64'sd13493037705 >>> 2;
    end else begin
      for (n = 1; n * k <= 62; n += 2) begin
        term = udiv(longint'(1) << (62 - n * k), longint'(n));
        s    = (sgn > 0) ? s + term : s - term;
        sgn  = -sgn;
      end
      s = (s + (longint'(1) << 29)) >>> 30;
    end
    return s;
  endfunction

  function automatic logic signed [IW-1:0] sx(logic [15:0] v);
    return IW'($signed(v[SAMPLE_BITS-1:0]));
  endfunction

endpackage

// ===== rtl/tofd_cordic.sv =====
// Pipelined CORDIC vectoring unit: angle of (i,q) in Q32 radians.
module tofd_cordic
  import tofd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic signed [IW-1:0] in_i,
  input  logic signed [IW-1:0] in_q,
  output logic                 out_valid,
  output logic signed [ZW-1:0] out_z
);

  typedef struct packed {
    logic                 valid;
    logic                 byp;
    logic                 ineg;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cor_t;

  cor_t st_r [CORDIC_STEPS+1];
  cor_t pre_nxt;

  always_comb begin
    pre_nxt       = '0;
    pre_nxt.valid = in_valid;
    pre_nxt.byp   = (in_q == '0);
    pre_nxt.ineg  = in_i[IW-1];
    if (in_i[IW-1]) begin
      pre_nxt.x = XW'(-in_i) <<< 30;
      pre_nxt.y = XW'(-in_q) <<< 30;
      pre_nxt.z = in_q[IW-1] ? -PI_Q32 : PI_Q32;
    end else begin
      pre_nxt.x = XW'(in_i) <<< 30;
      pre_nxt.y = XW'(in_q) <<< 30;
      pre_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r[0] <= '0;
    end else begin
      st_r[0] <= pre_nxt;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    localparam logic signed [ZW-1:0] ATAN_K = ZW'(atan_entry(k));
    cor_t st_nxt;
    always_comb begin
      st_nxt = st_r[k];
      if (st_r[k].y > 0) begin
        st_nxt.x = st_r[k].x + (st_r[k].y >>> k);
        st_nxt.y = st_r[k].y - (st_r[k].x >>> k);
        st_nxt.z = st_r[k].z + ATAN_K;
      end else begin
        st_nxt.x = st_r[k].x - (st_r[k].y >>> k);
        st_nxt.y = st_r[k].y + (st_r[k].x >>> k);
        st_nxt.z = st_r[k].z - ATAN_K;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k+1] <= '0;
      end else begin
        st_r[k+1] <= st_nxt;
      end
    end
  end

  // zero quadrature term: angle is exactly 0 or pi
  assign out_valid = st_r[CORDIC_STEPS].valid;
  assign out_z     = st_r[CORDIC_STEPS].byp ?
                     (st_r[CORDIC_STEPS].ineg ? PI_Q32 : '0) : st_r[CORDIC_STEPS].z;

endmodule

// ===== rtl/tofd_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module tofd_isqrt
  import tofd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [MAGW-1:0]   in_rad,
  output logic              out_valid,
  output logic [ROOTW-1:0]  out_root
);

  typedef struct packed {
    logic             valid;
    logic [MAGW-1:0]  rad;
    logic [REMW-1:0]  rem;
    logic [ROOTW-1:0] root;
  } sq_t;

  sq_t st_r [SQRT_STEPS+1];

  always_comb begin
    st_r[0]       = '0;
    st_r[0].valid = in_valid;
    st_r[0].rad   = in_rad;
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    sq_t             st_nxt;
    logic [REMW-1:0] rem_t;
    logic [REMW-1:0] trial;
    always_comb begin
      rem_t  = {st_r[j].rem[REMW-3:0], st_r[j].rad[MAGW-1:MAGW-2]};
      trial  = {1'b0, st_r[j].root, 2'b01};
      st_nxt = st_r[j];
      st_nxt.rad = st_r[j].rad << 2;
      if (rem_t >= trial) begin
        st_nxt.rem  = rem_t - trial;
        st_nxt.root = {st_r[j].root[ROOTW-2:0], 1'b1};
      end else begin
        st_nxt.rem  = rem_t;
        st_nxt.root = {st_r[j].root[ROOTW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[j+1] <= '0;
      end else begin
        st_r[j+1] <= st_nxt;
      end
    end
  end

  assign out_valid = st_r[SQRT_STEPS].valid;
  assign out_root  = st_r[SQRT_STEPS].root;

endmodule

// ===== rtl/tof_four_phase_depth.sv =====
// Top level: four-phase CW time-of-flight depth and amplitude per pixel.
//
// Usage:
//   Input: drive in_data with the four phase samples of one pixel and raise
//   start; the word is taken at every rising edge with start high. busy
//   stays low, so a pixel can be given in every cycle.
//   Output: out_valid is high for exactly one cycle with out_data holding
//   depth_mm and amplitude; the receiver must take it in that cycle.
//   Pipeline: 1 input register, 31 CORDIC stages, 5 phase/depth stages,
//   17 modulo stages, 1 output register. Throughput: one pixel per cycle,
//   set by the fully pipelined CORDIC, square root and modulo chains.
//   Configuration: cfg_valid with cfg_index and cfg_wdata writes the range
//   (index 0) or the depth offset (index 1); cfg_ready is always high.
//   Write only while no pixel is in flight.
//   Reset: synchronous, active low; clears all in-flight pixels and loads
//   range 15000 mm and offset 0.
module tof_four_phase_depth
  import tofd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_data,
  output logic      out_valid,
  output out_word_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [15:0]        range_r;
  logic signed [15:0] offset_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r  <= 16'd15000;
      offset_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RANGE:  range_r  <= cfg_wdata;
        CFG_OFFSET: offset_r <= $signed(cfg_wdata);
        default:    range_r  <= range_r;
      endcase
    end
  end

  // input register: in-phase and quadrature terms
  logic                 v0_r;
  logic signed [IW-1:0] i_r, q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
    i_r <= sx(in_data.second_plane_sample) - sx(in_data.first_plane_sample);
    q_r <= sx(in_data.fourth_plane_sample) - sx(in_data.third_plane_sample);
  end

  // amplitude path
  logic            v1_r, v2_r;
  logic [MAGW-1:0] ii_r, qq_r, mag_r;
  logic            root_valid;
  logic [ROOTW-1:0] root;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
    ii_r  <= MAGW'(i_r) * MAGW'(i_r);
    qq_r  <= MAGW'(q_r) * MAGW'(q_r);
    mag_r <= ii_r + qq_r;
  end

  tofd_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v2_r),
    .in_rad   (mag_r),
    .out_valid(root_valid),
    .out_root (root)
  );

  // hold the root until the depth of the same pixel arrives
  logic [ROOTW-1:0] amp_dly_r [AMP_DLY];

  always_ff @(posedge clk) begin
    amp_dly_r[0] <= root;
    for (int k = 1; k < AMP_DLY; k++) begin
      amp_dly_r[k] <= amp_dly_r[k-1];
    end
  end

  // angle path
  logic                 cor_valid;
  logic signed [ZW-1:0] cor_z;

  tofd_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v0_r),
    .in_i     (i_r),
    .in_q     (q_r),
    .out_valid(cor_valid),
    .out_z    (cor_z)
  );

  logic                   vt_r, vp_r, vq_r, vd_r;
  logic [TW-1:0]          t_r;
  logic [TW-TLW+INVW-1:0] ph_r;
  logic [TLW+INVW-1:0]    pl_r;
  logic [PW-1:0]          p_r;
  logic signed [DW-1:0]   d_r;
  logic signed [ZW:0]     t_sum;
  logic [SUMW-1:0]        p_sum;
  logic [PW:0]            p_raw;

  always_comb begin
    t_sum = {cor_z[ZW-1], cor_z} + {PI_Q32[ZW-1], PI_Q32};
    p_sum = (SUMW'(ph_r) << TLW) + SUMW'(pl_r) + (SUMW'(1) << (60 - PHASE_BITS));
    p_raw = p_sum[SUMW-1 -: PW+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r <= 1'b0;
      vp_r <= 1'b0;
      vq_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      vt_r <= cor_valid;
      vp_r <= vt_r;
      vq_r <= vp_r;
      vd_r <= vq_r;
    end
    // clamp the turn to [0, 2*pi]
    priority if (t_sum[ZW]) begin
      t_r <= '0;
    end else if (t_sum > $signed({3'b0, TWO_PI_Q32})) begin
      t_r <= TWO_PI_Q32;
    end else begin
      t_r <= TW'(t_sum);
    end
    ph_r <= t_r[TW-1:TLW] * INV_TWO_PI;
    pl_r <= t_r[TLW-1:0] * INV_TWO_PI;
    if (p_raw > (PW+1)'(1 << PHASE_BITS)) begin
      p_r <= PW'(1 << PHASE_BITS);
    end else begin
      p_r <= PW'(p_raw);
    end
    d_r <= $signed({2'b0, {16'b0, p_r} * {17'b0, range_r}})
           + ($signed(DW'(offset_r)) <<< PHASE_BITS);
  end

  // wrap decision and modulo by the range, one quotient bit per stage
  typedef struct packed {
    logic        valid;
    logic        wrap;
    logic        zr;
    logic        bhi;
    logic [16:0] mm_pass;
    logic [16:0] a;
    logic [16:0] rem;
  } div_t;

  div_t                 div_r [DIV_STEPS+1];
  logic signed [DW-1:0] d_rnd;
  logic [DW-2:0]        top;

  always_comb begin
    d_rnd = d_r + DW'(1 << (PHASE_BITS - 1));
    top   = (DW-1)'({range_r, PHASE_BITS'(0)});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r[0] <= '0;
    end else begin
      div_r[0].valid   <= vd_r;
      div_r[0].wrap    <= !d_r[DW-1] && (d_r[DW-2:0] > top);
      div_r[0].zr      <= (range_r == '0);
      div_r[0].bhi     <= d_r[PHASE_BITS-1];
      div_r[0].mm_pass <= d_rnd[PHASE_BITS+16:PHASE_BITS];
      div_r[0].a       <= d_r[PHASE_BITS+16:PHASE_BITS];
      div_r[0].rem     <= '0;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    div_t        div_nxt;
    logic [16:0] rem_t;
    always_comb begin
      rem_t   = {div_r[j].rem[15:0], div_r[j].a[16]};
      div_nxt = div_r[j];
      div_nxt.a = div_r[j].a << 1;
      if (rem_t >= {1'b0, range_r}) begin
        div_nxt.rem = rem_t - {1'b0, range_r};
      end else begin
        div_nxt.rem = rem_t;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_r[j+1] <= '0;
      end else begin
        div_r[j+1] <= div_nxt;
      end
    end
  end

  div_t             dl;
  logic [16:0]      mm_wrap;
  logic [ROOTW:0]   amp_sum;

  always_comb begin
    dl      = div_r[DIV_STEPS];
    mm_wrap = dl.rem + 17'(dl.bhi);
    amp_sum = {1'b0, amp_dly_r[AMP_DLY-1]} + (ROOTW+1)'(1);
  end

  logic      out_valid_r;
  out_word_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dl.valid;
    end
    priority if (dl.wrap && dl.zr) begin
      out_data_r.depth_mm <= '0;
    end else if (dl.wrap) begin
      out_data_r.depth_mm <= $signed(mm_wrap);
    end else begin
      out_data_r.depth_mm <= $signed(dl.mm_pass);
    end
    out_data_r.amplitude <= amp_sum[16:1];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(LATENCY+1) out_valid)
    else $error("accepted pixel did not come out after the pipeline latency");

  a_amp_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.amplitude <= 16'd46341)
    else $error("amplitude above half the largest magnitude");

  a_depth_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $signed(out_data.depth_mm) <= $signed({1'b0, range_r}))
    else $error("depth above unambiguous range after wrap");

  a_root_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    root_valid |-> ##AMP_DLY dl.valid)
    else $error("amplitude and depth of one pixel out of step");

endmodule
